// ===== sv/pa3_pkg.sv =====
package pa3_pkg;

	localparam int IN_CW   = 24;
	localparam int IDX_W   = 10;
	localparam int AREA_W  = 54;
	localparam int MAG_W   = 64;
	localparam int HALF_W  = 32;
	localparam int SQ_W    = 128;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_VERTEX = 1'b1;

	typedef struct packed {
		logic                    func;
		logic [IDX_W-1:0]        node_index;
		logic signed [IN_CW-1:0] coord_x;
		logic signed [IN_CW-1:0] coord_y;
		logic signed [IN_CW-1:0] coord_z;
		logic                    last_vertex;
	} in_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic              saturated;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIFF,
		ST_MUL,
		ST_ACC,
		ST_SQ,
		ST_ROOT_GO,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage

// ===== sv/pa3_isqrt.sv =====
module pa3_isqrt
	import pa3_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   value,
	output logic              done,
	output logic [MAG_W-1:0]  root
);

	logic [MAG_W+1:0]   rem_q;
	logic [MAG_W-1:0]   root_q;
	logic [SQ_W-1:0]    val_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MAG_W+1:0]   rem_sh;
	logic [MAG_W+1:0]   trial;
	logic               take;

	// One result bit per cycle, restoring method on two radicand bits a step.
	always_comb begin
		rem_sh = {rem_q[MAG_W-1:0], val_q[SQ_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			val_q  <= value;
		end else if (busy_q) begin
			val_q <= {val_q[SQ_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== sv/polygon_area_3d.sv =====
// Vector area of a planar polygon in 3D, from a table of stored nodes.
// Input channel (in_valid, in_stall, in_item): a transfer with func = load
// writes one node into the node memory if node_index is in range; the input
// stays open. A transfer with func = vertex reads the node at node_index
// (zero if out of range); the polygon is fanned from its first vertex and
// each vertex from the third on adds a cross product to three saturating
// accumulators. A vertex passes memory read, difference, multiply and
// accumulate, then the input opens again. On the vertex marked last the block
// squares the three sums with one 32x32 multiplier, takes a 128-bit integer
// square root one bit per cycle (the dominant cost) and delivers half the
// root as the area. Fewer than three vertices give zero.
// Output channel (out_valid, out_stall, out_item): one result register. A new
// item is taken while a result waits; if a second result is ready before the
// first is taken, the block holds it and keeps in_stall high until the
// receiver releases out_stall.
// Reset clears the polygon state and the channels; the node memory holds
// nothing defined until loaded.
module polygon_area_3d
	import pa3_pkg::*;
#(
	parameter int NODE_DEPTH  = 1024,
	parameter int COORD_WIDTH = 24,
	parameter int ACC_WIDTH   = 56
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_item,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_item
);

	localparam int AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int TW = PW + 1;
	localparam int SW = ((ACC_WIDTH > TW) ? ACC_WIDTH : TW) + 1;

	state_t state_q, state_d;

	logic [3*CW-1:0] node_mem [NODE_DEPTH];
	logic [3*CW-1:0] rd_q;
	logic [AW-1:0]   addr;
	logic            in_acc;
	logic            in_range;
	logic            mem_we;
	logic            range_q;
	logic            last_q;

	logic signed [CW-1:0] cur_x_q, cur_y_q, cur_z_q;
	logic signed [CW-1:0] first_x_q, first_y_q, first_z_q;
	logic signed [CW-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [1:0]           count_q;

	logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [PW-1:0] ay_bz_q, az_by_q, az_bx_q, ax_bz_q, ax_by_q, ay_bx_q;
	logic signed [TW-1:0] term_i, term_j, term_k;
	logic [ACC_WIDTH:0]   add_i, add_j, add_k;

	logic signed [ACC_WIDTH-1:0] sum_i_q, sum_j_q, sum_k_q;
	logic                        ovf_q;

	logic [3:0]          sq_cnt_q;
	logic [1:0]          sq_sel;
	logic [1:0]          sq_part;
	logic signed [ACC_WIDTH-1:0] sq_src;
	logic [MAG_W-1:0]    sq_ext;
	logic [MAG_W-1:0]    sq_mag;
	logic [HALF_W-1:0]   mul_a, mul_b;
	logic [MAG_W-1:0]    prod_q;
	logic [1:0]          prod_sh_q;
	logic                prod_vld_q;
	logic [SQ_W-1:0]     prod_ext;
	logic [SQ_W-1:0]     sq_sum_q;

	logic                sqrt_start;
	logic                sqrt_done;
	logic [MAG_W-1:0]    sqrt_root;
	logic [MAG_W-1:0]    root_q;
	logic                area_clamp;
	logic [AREA_W-1:0]   area_val;

	logic out_load;
	logic out_valid_q;
	out_t out_q;

	// Saturating add of a cross-product term; the top bit reports saturation.
	function automatic logic [ACC_WIDTH:0] sat_add(
		input logic signed [ACC_WIDTH-1:0] a,
		input logic signed [TW-1:0]        t
	);
		logic signed [SW-1:0] s;
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		s  = SW'(a) + SW'(t);
		hi = (SW'(1) <<< (ACC_WIDTH - 1)) - SW'(1);
		lo = -hi - SW'(1);
		if (s > hi) begin
			sat_add = {1'b1, hi[ACC_WIDTH-1:0]};
		end else if (s < lo) begin
			sat_add = {1'b1, lo[ACC_WIDTH-1:0]};
		end else begin
			sat_add = {1'b0, s[ACC_WIDTH-1:0]};
		end
	endfunction

	assign in_acc   = in_valid && !in_stall;
	assign addr     = AW'(in_item.node_index);
	assign in_range = (32'(in_item.node_index) < NODE_DEPTH);
	assign mem_we   = in_acc && (in_item.func == FUNC_LOAD) && in_range;

	// Node memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[addr] <= {in_item.coord_x[CW-1:0], in_item.coord_y[CW-1:0],
				in_item.coord_z[CW-1:0]};
		end
		rd_q <= node_mem[addr];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_item.func == FUNC_VERTEX)) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH:   state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_MUL;
			ST_MUL:     state_d = ST_ACC;
			ST_ACC:     state_d = last_q ? ST_SQ : ST_IDLE;
			ST_SQ: begin
				if (sq_cnt_q == 4'd9) begin
					state_d = ST_ROOT_GO;
				end
			end
			ST_ROOT_GO: state_d = ST_ROOT;
			ST_ROOT: begin
				if (sqrt_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		sqrt_start = (state_q == ST_ROOT_GO);
		out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cross-product terms of the fan triangle.
	always_comb begin
		term_i = TW'(ay_bz_q) - TW'(az_by_q);
		term_j = TW'(az_bx_q) - TW'(ax_bz_q);
		term_k = TW'(ax_by_q) - TW'(ay_bx_q);
		add_i  = sat_add(sum_i_q, term_i);
		add_j  = sat_add(sum_j_q, term_j);
		add_k  = sat_add(sum_k_q, term_k);
	end

	// Vertex datapath without reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			range_q <= in_range;
			last_q  <= in_item.last_vertex;
		end
		if (state_q == ST_FETCH) begin
			if (range_q) begin
				cur_x_q <= rd_q[3*CW-1 -: CW];
				cur_y_q <= rd_q[2*CW-1 -: CW];
				cur_z_q <= rd_q[CW-1:0];
			end else begin
				cur_x_q <= '0;
				cur_y_q <= '0;
				cur_z_q <= '0;
			end
		end
		if (state_q == ST_DIFF) begin
			ax_q <= DW'(prev_x_q) - DW'(first_x_q);
			ay_q <= DW'(prev_y_q) - DW'(first_y_q);
			az_q <= DW'(prev_z_q) - DW'(first_z_q);
			bx_q <= DW'(cur_x_q) - DW'(first_x_q);
			by_q <= DW'(cur_y_q) - DW'(first_y_q);
			bz_q <= DW'(cur_z_q) - DW'(first_z_q);
		end
		if (state_q == ST_MUL) begin
			ay_bz_q <= PW'(ay_q) * PW'(bz_q);
			az_by_q <= PW'(az_q) * PW'(by_q);
			az_bx_q <= PW'(az_q) * PW'(bx_q);
			ax_bz_q <= PW'(ax_q) * PW'(bz_q);
			ax_by_q <= PW'(ax_q) * PW'(by_q);
			ay_bx_q <= PW'(ay_q) * PW'(bx_q);
		end
		if (state_q == ST_ACC) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			prev_z_q <= cur_z_q;
			if (count_q == 2'd0) begin
				first_x_q <= cur_x_q;
				first_y_q <= cur_y_q;
				first_z_q <= cur_z_q;
			end
		end
	end

	// Polygon state: vertex count, sums and the saturation flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_i_q <= '0;
			sum_j_q <= '0;
			sum_k_q <= '0;
			ovf_q   <= 1'b0;
		end else if (state_q == ST_ACC) begin
			if (count_q == 2'd2) begin
				sum_i_q <= add_i[ACC_WIDTH-1:0];
				sum_j_q <= add_j[ACC_WIDTH-1:0];
				sum_k_q <= add_k[ACC_WIDTH-1:0];
				ovf_q   <= ovf_q | add_i[ACC_WIDTH] | add_j[ACC_WIDTH] | add_k[ACC_WIDTH];
			end else begin
				count_q <= count_q + 2'd1;
			end
		end else if (out_load) begin
			count_q <= '0;
			sum_i_q <= '0;
			sum_j_q <= '0;
			sum_k_q <= '0;
			ovf_q   <= 1'b0;
		end
	end

	// Square sequence: three partial products per sum, one per cycle.
	always_comb begin
		case (sq_cnt_q)
			4'd0:    begin sq_sel = 2'd0; sq_part = 2'd0; end
			4'd1:    begin sq_sel = 2'd0; sq_part = 2'd1; end
			4'd2:    begin sq_sel = 2'd0; sq_part = 2'd2; end
			4'd3:    begin sq_sel = 2'd1; sq_part = 2'd0; end
			4'd4:    begin sq_sel = 2'd1; sq_part = 2'd1; end
			4'd5:    begin sq_sel = 2'd1; sq_part = 2'd2; end
			4'd6:    begin sq_sel = 2'd2; sq_part = 2'd0; end
			4'd7:    begin sq_sel = 2'd2; sq_part = 2'd1; end
			4'd8:    begin sq_sel = 2'd2; sq_part = 2'd2; end
			default: begin sq_sel = 2'd0; sq_part = 2'd0; end
		endcase
		case (sq_sel)
			2'd0:    sq_src = sum_i_q;
			2'd1:    sq_src = sum_j_q;
			default: sq_src = sum_k_q;
		endcase
		sq_ext = MAG_W'(sq_src);
		sq_mag = sq_ext[MAG_W-1] ? (MAG_W'(0) - sq_ext) : sq_ext;
		case (sq_part)
			2'd0:    begin mul_a = sq_mag[HALF_W-1:0]; mul_b = sq_mag[HALF_W-1:0]; end
			2'd1:    begin mul_a = sq_mag[HALF_W-1:0]; mul_b = sq_mag[MAG_W-1:HALF_W]; end
			default: begin mul_a = sq_mag[MAG_W-1:HALF_W]; mul_b = sq_mag[MAG_W-1:HALF_W]; end
		endcase
		case (prod_sh_q)
			2'd0:    prod_ext = SQ_W'(prod_q);
			2'd1:    prod_ext = SQ_W'(prod_q) << (HALF_W + 1);
			default: prod_ext = SQ_W'(prod_q) << MAG_W;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q   <= '0;
			prod_vld_q <= 1'b0;
		end else if (state_q == ST_SQ) begin
			sq_cnt_q   <= sq_cnt_q + 4'd1;
			prod_vld_q <= (sq_cnt_q != 4'd9);
		end else begin
			sq_cnt_q   <= '0;
			prod_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SQ) begin
			prod_q    <= MAG_W'(mul_a) * MAG_W'(mul_b);
			prod_sh_q <= sq_part;
			if (prod_vld_q) begin
				sq_sum_q <= sq_sum_q + prod_ext;
			end
		end else begin
			sq_sum_q <= '0;
		end
		if (sqrt_done) begin
			root_q <= sqrt_root;
		end
	end

	pa3_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (sq_sum_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// Half the root, clamped to the area field.
	always_comb begin
		area_clamp = |root_q[MAG_W-1:AREA_W+1];
		area_val   = area_clamp ? '1 : root_q[AREA_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.area      <= area_val;
			out_q.saturated <= ovf_q | area_clamp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
